@@ rtl/kcmt_pkg.sv @@
package kcmt_pkg;

	localparam int ENTRIES    = 64;
	localparam int COUNT_BITS = 16;
	localparam int IDX_W      = $clog2(ENTRIES);
	localparam int KEY_W      = 50;
	localparam int OUT_CNT_W  = 16;

	typedef logic [KEY_W-1:0]      key_t;
	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [OUT_CNT_W-1:0]  out_cnt_t;

	localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam idx_t   LAST_IDX  = IDX_W'(ENTRIES - 1);

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_FULL   = 2'd1,
		STAT_ABSENT = 2'd2,
		STAT_SAT    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_COMMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_last;
	} dp_stat_t;

	// low bits of a count for the result ports, zero-extended when narrow
	function automatic out_cnt_t out_count(count_t c);
		logic [COUNT_BITS+OUT_CNT_W-1:0] wide;
		wide = {{OUT_CNT_W{1'b0}}, c};
		return wide[OUT_CNT_W-1:0];
	endfunction

endpackage

@@ rtl/kcmt_ctrl.sv @@
module kcmt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  kcmt_pkg::dp_stat_t stat,
	output kcmt_pkg::dp_cmd_t  cmd
);
	import kcmt_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   can_commit;

	// result register free, or being emptied this cycle
	assign can_commit = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_SCAN;
			end
			S_SCAN: begin
				if (stat.scan_last) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				if (can_commit) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd        = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_SCAN: begin
				cmd.rd = 1'b1;
			end
			S_COMMIT: begin
				cmd.commit = can_commit;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ rtl/kcmt_dp.sv @@
module kcmt_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  kcmt_pkg::dp_cmd_t  cmd,
	output kcmt_pkg::dp_stat_t stat,
	input  logic               action,
	input  kcmt_pkg::key_t     key,
	output kcmt_pkg::key_t     max_key,
	output kcmt_pkg::out_cnt_t max_count,
	output kcmt_pkg::key_t     min_key,
	output kcmt_pkg::out_cnt_t min_count,
	output logic               is_empty,
	output logic [1:0]         status
);
	import kcmt_pkg::*;

	// slot store: key and count share one address
	key_t   mem_key [ENTRIES];
	count_t mem_cnt [ENTRIES];
	logic [ENTRIES-1:0] slot_valid_q;

	// request
	logic action_q;
	key_t key_q;
	idx_t addr_q;

	// read stage
	logic   rd_s1;
	idx_t   idx_s1;
	logic   vld_s1;
	key_t   key_s1;
	count_t cnt_s1;

	// scan accumulators; the matching slot is kept out of min/max
	logic   hit_q, free_q, any_q;
	idx_t   hit_idx_q, free_idx_q, mx_idx_q, mn_idx_q;
	count_t hit_cnt_q, mx_c_q, mn_c_q;
	key_t   mx_k_q, mn_k_q;

	// result registers
	key_t     max_key_q, min_key_q;
	out_cnt_t max_count_q, min_count_q;
	logic     is_empty_q;
	status_t  status_q;

	// update and merge
	idx_t    upd_idx;
	count_t  upd_cnt;
	logic    live, wr, set_v, clr_v;
	status_t upd_stat;
	logic    take_mx, take_mn, res_any;

	assign stat.scan_last = (addr_q == LAST_IDX);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= action;
			key_q    <= key;
			addr_q   <= '0;
		end else if (cmd.rd) begin
			addr_q <= addr_q + IDX_W'(1);
		end
		if (cmd.rd) begin
			key_s1 <= mem_key[addr_q];
			cnt_s1 <= mem_cnt[addr_q];
			idx_s1 <= addr_q;
			vld_s1 <= slot_valid_q[addr_q];
		end
		if (wr) begin
			mem_key[upd_idx] <= key_q;
			mem_cnt[upd_idx] <= upd_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= cmd.rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
		end else if (set_v) begin
			slot_valid_q[upd_idx] <= 1'b1;
		end else if (clr_v) begin
			slot_valid_q[upd_idx] <= 1'b0;
		end
	end

	// slots arrive in ascending order, so strict compares keep the lowest slot
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
			any_q  <= 1'b0;
		end else if (rd_s1) begin
			if (vld_s1) begin
				if (key_s1 == key_q) begin
					hit_q     <= 1'b1;
					hit_idx_q <= idx_s1;
					hit_cnt_q <= cnt_s1;
				end else if (!any_q) begin
					any_q    <= 1'b1;
					mx_c_q   <= cnt_s1;
					mx_k_q   <= key_s1;
					mx_idx_q <= idx_s1;
					mn_c_q   <= cnt_s1;
					mn_k_q   <= key_s1;
					mn_idx_q <= idx_s1;
				end else begin
					if (cnt_s1 > mx_c_q) begin
						mx_c_q   <= cnt_s1;
						mx_k_q   <= key_s1;
						mx_idx_q <= idx_s1;
					end
					if (cnt_s1 < mn_c_q) begin
						mn_c_q   <= cnt_s1;
						mn_k_q   <= key_s1;
						mn_idx_q <= idx_s1;
					end
				end
			end else if (!free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= idx_s1;
			end
		end
	end

	always_comb begin
		upd_idx  = hit_idx_q;
		upd_cnt  = hit_cnt_q;
		live     = 1'b0;
		wr       = 1'b0;
		set_v    = 1'b0;
		clr_v    = 1'b0;
		upd_stat = STAT_OK;
		if (!action_q) begin
			if (hit_q) begin
				live = 1'b1;
				wr   = cmd.commit;
				if (hit_cnt_q == COUNT_MAX)
					upd_stat = STAT_SAT;
				else
					upd_cnt = hit_cnt_q + COUNT_BITS'(1);
			end else if (free_q) begin
				upd_idx = free_idx_q;
				upd_cnt = COUNT_BITS'(1);
				live    = 1'b1;
				wr      = cmd.commit;
				set_v   = cmd.commit;
			end else begin
				upd_stat = STAT_FULL;
			end
		end else begin
			if (!hit_q) begin
				upd_stat = STAT_ABSENT;
			end else if (hit_cnt_q <= COUNT_BITS'(1)) begin
				clr_v = cmd.commit;
			end else begin
				upd_cnt = hit_cnt_q - COUNT_BITS'(1);
				live    = 1'b1;
				wr      = cmd.commit;
			end
		end
	end

	// fold the updated slot into the scan of the others, ties to lower slot
	assign take_mx = live && (!any_q || (upd_cnt > mx_c_q) ||
		((upd_cnt == mx_c_q) && (upd_idx < mx_idx_q)));
	assign take_mn = live && (!any_q || (upd_cnt < mn_c_q) ||
		((upd_cnt == mn_c_q) && (upd_idx < mn_idx_q)));
	assign res_any = any_q || live;

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q   <= upd_stat;
			is_empty_q <= !res_any;
			if (!res_any) begin
				max_key_q   <= '0;
				max_count_q <= '0;
				min_key_q   <= '0;
				min_count_q <= '0;
			end else begin
				max_key_q   <= take_mx ? key_q : mx_k_q;
				max_count_q <= out_count(take_mx ? upd_cnt : mx_c_q);
				min_key_q   <= take_mn ? key_q : mn_k_q;
				min_count_q <= out_count(take_mn ? upd_cnt : mn_c_q);
			end
		end
	end

	assign max_key   = max_key_q;
	assign max_count = max_count_q;
	assign min_key   = min_key_q;
	assign min_count = min_count_q;
	assign is_empty  = is_empty_q;
	assign status    = status_q;

endmodule

@@ rtl/key_count_min_max_tracker.sv @@
// channel | handshake          | payload
// in      | in_valid/in_ready   | action, key
// out     | out_valid/out_ready | max_key, max_count, min_key, min_count, is_empty, status
//
// One request at a time: accept, ENTRIES slot reads (one per cycle from the
// slot store), a drain step for the read register, then a commit step;
// the next request is taken only after the commit.
// Reset clears the slot valid flags at once; slot data is not cleared.
// The result register lets the next request be taken while a result waits;
// commit of the following request holds until that result is taken.
module key_count_min_max_tracker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               action,
	input  kcmt_pkg::key_t     key,
	output logic               out_valid,
	input  logic               out_ready,
	output kcmt_pkg::key_t     max_key,
	output kcmt_pkg::out_cnt_t max_count,
	output kcmt_pkg::key_t     min_key,
	output kcmt_pkg::out_cnt_t min_count,
	output logic               is_empty,
	output logic [1:0]         status
);
	import kcmt_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	kcmt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	kcmt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.action    (action),
		.key       (key),
		.max_key   (max_key),
		.max_count (max_count),
		.min_key   (min_key),
		.min_count (min_count),
		.is_empty  (is_empty),
		.status    (status)
	);

`ifndef SYNTHESIS
	a_accept_busy : assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while a scan was starting");

	a_empty_zero : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_empty |-> max_count == '0 && min_count == '0 &&
			max_key == '0 && min_key == '0)
		else $error("empty table reported non-zero result");

	a_sat_live : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_SAT |-> !is_empty)
		else $error("saturated count reported with empty table");

	a_commit_idle : assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !in_ready && !cmd.rd)
		else $error("commit overlaps scan or accept");
`endif

endmodule

@@ sim/tb.sv @@
module tb;
	import kcmt_pkg::*;

	localparam logic ACT_INC         = 1'b0;
	localparam logic ACT_DEC         = 1'b1;
	localparam int   REQUEST_BUDGET  = 1500;
	localparam int   HOLD_OFF_CYCLES = 400;
	localparam int   CYCLE_LIMIT     = 1_000_000;

	localparam key_t KEY_ONES   = {KEY_W{1'b1}};
	localparam key_t KEY_ZERO   = '0;
	localparam key_t KEY_A      = 50'd1;
	localparam key_t KEY_ABC    = 50'd3137;          // "abc": a in bits 4:0, c in 14:10
	localparam key_t KEY_ALT_HI = 50'h2AAAAAAAAAAAA;
	localparam key_t KEY_ALT_LO = 50'h1555555555555;
	localparam key_t KEY_TOP    = 50'h2000000000000;

	typedef struct packed {
		key_t     max_key;
		out_cnt_t max_count;
		key_t     min_key;
		out_cnt_t min_count;
		logic     is_empty;
		status_t  status;
	} report_t;

	typedef struct {
		logic    act;
		key_t    k;
		bit      typed;
		report_t want;
	} dir_row_t;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     in_valid  = 1'b0;
	logic     in_ready;
	logic     action    = 1'b0;
	key_t     key       = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	key_t     max_key;
	out_cnt_t max_count;
	key_t     min_key;
	out_cnt_t min_count;
	logic     is_empty;
	logic [1:0] status;

	// shadow of the slot table
	bit      tbl_used [ENTRIES];
	key_t    tbl_key  [ENTRIES];
	count_t  tbl_cnt  [ENTRIES];
	report_t pending_reports [$];

	int status_tally [4];
	int peak_fill;
	int peak_count;
	int results_checked;
	int mismatches;
	int cycle_count;
	int sent_count;
	int hold_off;
	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;

	key_count_min_max_tracker i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.key       (key),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.max_key   (max_key),
		.max_count (max_count),
		.min_key   (min_key),
		.min_count (min_count),
		.is_empty  (is_empty),
		.status    (status)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$error("timed out after %0d cycles, %0d requests outstanding",
				cycle_count, pending_reports.size());
			$display("status: fail");
			$finish;
		end
	end

	// apply one request to the shadow table and work out the min/max report
	function automatic report_t apply_request(logic act, key_t k);
		report_t r;
		int      i;
		int      hit;
		int      spare;
		int      fill;
		logic    seen;
		count_t  hi_c;
		count_t  lo_c;
		key_t    hi_k;
		key_t    lo_k;
		status_t st;
		hit   = -1;
		spare = -1;
		for (i = ENTRIES - 1; i >= 0; i--) begin
			if (tbl_used[i] && tbl_key[i] == k)
				hit = i;
			if (!tbl_used[i])
				spare = i;
		end
		st = STAT_OK;
		if (act == ACT_INC) begin
			if (hit >= 0) begin
				if (tbl_cnt[hit] == COUNT_MAX)
					st = STAT_SAT;
				else
					tbl_cnt[hit] = tbl_cnt[hit] + 1'b1;
			end else if (spare < 0) begin
				st = STAT_FULL;
			end else begin
				tbl_used[spare] = 1'b1;
				tbl_key[spare]  = k;
				tbl_cnt[spare]  = count_t'(1);
			end
		end else begin
			if (hit < 0) begin
				st = STAT_ABSENT;
			end else if (tbl_cnt[hit] <= 1) begin
				tbl_used[hit] = 1'b0;
				tbl_cnt[hit]  = '0;
			end else begin
				tbl_cnt[hit] = tbl_cnt[hit] - 1'b1;
			end
		end
		seen = 1'b0;
		fill = 0;
		hi_c = '0;
		lo_c = '0;
		hi_k = '0;
		lo_k = '0;
		// strict compares keep the lowest slot on a tie
		for (i = 0; i < ENTRIES; i++) begin
			if (tbl_used[i]) begin
				if (!seen || tbl_cnt[i] > hi_c) begin
					hi_c = tbl_cnt[i];
					hi_k = tbl_key[i];
				end
				if (!seen || tbl_cnt[i] < lo_c) begin
					lo_c = tbl_cnt[i];
					lo_k = tbl_key[i];
				end
				seen = 1'b1;
				fill++;
			end
		end
		r.max_key   = hi_k;
		r.max_count = out_cnt_t'(hi_c);
		r.min_key   = lo_k;
		r.min_count = out_cnt_t'(lo_c);
		r.is_empty  = !seen;
		r.status    = st;
		status_tally[st]++;
		if (fill > peak_fill)
			peak_fill = fill;
		if (int'(hi_c) > peak_count)
			peak_count = int'(hi_c);
		return r;
	endfunction

	function automatic key_t make_key();
		key_t k;
		int   n;
		int   j;
		if ($urandom_range(0, 4) == 0)
			return key_t'({$urandom, $urandom});
		k = '0;
		n = $urandom_range(1, 10);
		for (j = 0; j < n; j++)
			k[5*j +: 5] = 5'($urandom_range(1, 26));
		return k;
	endfunction

	function automatic dir_row_t plain_row(logic act, key_t k);
		dir_row_t row;
		row.act   = act;
		row.k     = k;
		row.typed = 1'b0;
		row.want  = '0;
		return row;
	endfunction

	function automatic dir_row_t typed_row(logic act, key_t k, key_t mk, out_cnt_t mc,
			key_t nk, out_cnt_t nc, logic e, status_t st);
		dir_row_t row;
		row.act            = act;
		row.k              = k;
		row.typed          = 1'b1;
		row.want.max_key   = mk;
		row.want.max_count = mc;
		row.want.min_key   = nk;
		row.want.min_count = nc;
		row.want.is_empty  = e;
		row.want.status    = st;
		return row;
	endfunction

	task automatic offer(input logic act, input key_t k, input bit typed,
			input report_t typed_want);
		report_t want;
		int      gap;
		want = apply_request(act, k);
		if (typed)
			want = typed_want;
		gap = tx_idle ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		action   <= act;
		key      <= k;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		pending_reports.push_back(want);
		sent_count++;
	endtask

	// decrement every stored key down to nothing
	task automatic drain_table();
		int i;
		for (i = 0; i < ENTRIES; i++)
			while (tbl_used[i])
				offer(ACT_DEC, tbl_key[i], 1'b0, '0);
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : result_check
		report_t want;
		if (out_valid === 1'b1 && out_ready) begin
			if (pending_reports.size() == 0) begin
				$error("result with no request outstanding");
				mismatches++;
			end else begin
				want = pending_reports.pop_front();
				results_checked++;
				check_field("max_key",   want.max_key,   max_key);
				check_field("max_count", want.max_count, max_count);
				check_field("min_key",   want.min_key,   min_key);
				check_field("min_count", want.min_count, min_count);
				check_field("is_empty",  want.is_empty,  is_empty);
				check_field("status",    want.status,    status);
			end
		end
	end

	initial begin : result_sink
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = rx_idle ? $urandom_range(0, 15) : 0;
			if (hold_off > 0) begin
				stall    = hold_off;
				hold_off = 0;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin : request_source
		dir_row_t rows [$];
		key_t     pool [$];
		int       kind;
		int       n;
		int       inc_pct;
		bit       first_phase;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		rows.push_back(typed_row(ACT_DEC, KEY_A, '0, '0, '0, '0, 1'b1, STAT_ABSENT));
		rows.push_back(typed_row(ACT_INC, KEY_ONES, KEY_ONES, 16'd1, KEY_ONES, 16'd1, 1'b0,
			STAT_OK));
		rows.push_back(plain_row(ACT_INC, KEY_ZERO));
		// only key zero left: reported as 0 but the table is not empty
		rows.push_back(typed_row(ACT_DEC, KEY_ONES, KEY_ZERO, 16'd1, KEY_ZERO, 16'd1, 1'b0,
			STAT_OK));
		rows.push_back(typed_row(ACT_DEC, KEY_ZERO, '0, '0, '0, '0, 1'b1, STAT_OK));
		rows.push_back(typed_row(ACT_DEC, KEY_ZERO, '0, '0, '0, '0, 1'b1, STAT_ABSENT));
		rows.push_back(plain_row(ACT_INC, KEY_ABC));
		rows.push_back(plain_row(ACT_INC, KEY_ABC));
		rows.push_back(plain_row(ACT_INC, KEY_ALT_HI));
		rows.push_back(plain_row(ACT_INC, KEY_ALT_LO));
		rows.push_back(plain_row(ACT_INC, KEY_ALT_LO));
		rows.push_back(plain_row(ACT_INC, KEY_ALT_LO));
		rows.push_back(plain_row(ACT_DEC, KEY_ABC));
		rows.push_back(plain_row(ACT_INC, KEY_TOP));
		rows.push_back(plain_row(ACT_DEC, KEY_ALT_HI));
		rows.push_back(plain_row(ACT_INC, KEY_A));        // reuses the freed slot
		rows.push_back(plain_row(ACT_DEC, KEY_ALT_LO));
		rows.push_back(plain_row(ACT_INC, KEY_ABC));
		rows.push_back(plain_row(ACT_DEC, KEY_ONES));
		rows.push_back(plain_row(ACT_DEC, KEY_ABC));
		rows.push_back(plain_row(ACT_DEC, KEY_ABC));
		rows.push_back(plain_row(ACT_INC, KEY_ZERO));
		rows.push_back(plain_row(ACT_INC, KEY_ONES));
		foreach (rows[r])
			offer(rows[r].act, rows[r].k, rows[r].typed, rows[r].want);

		first_phase = 1'b1;
		while (sent_count < REQUEST_BUDGET) begin
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			kind    = $urandom_range(0, 9);
			if (first_phase) begin
				// sink stalls while requests keep coming: input side must back up
				hold_off    = HOLD_OFF_CYCLES;
				tx_idle     = 1'b0;
				kind        = 0;
				first_phase = 1'b0;
			end
			if (kind <= 4 || kind == 8) begin
				// churn on a few keys; the dec-heavy variant hits removal and absent keys
				inc_pct = (kind == 8) ? 40 : 60;
				n = (kind == 8) ? $urandom_range(2, 4) : $urandom_range(2, 12);
				pool = {};
				repeat (n) pool.push_back(make_key());
				repeat (40)
					offer(($urandom_range(0, 99) < inc_pct) ? ACT_INC : ACT_DEC,
						pool[$urandom_range(0, pool.size() - 1)], 1'b0, '0);
			end else if (kind <= 6) begin
				// more keys than slots, so the tail of the fill gets dropped
				pool = {};
				repeat (ENTRIES + 6) pool.push_back(make_key());
				foreach (pool[p])
					offer(ACT_INC, pool[p], 1'b0, '0);
				repeat (30)
					offer(($urandom_range(0, 3) == 0) ? ACT_DEC : ACT_INC,
						pool[$urandom_range(0, pool.size() - 1)], 1'b0, '0);
				drain_table();
			end else if (kind == 7) begin
				repeat (20)
					offer(1'($urandom_range(0, 1)), key_t'({$urandom, $urandom}), 1'b0, '0);
			end else begin
				drain_table();
			end
		end

		tx_idle = 1'b0;
		rx_idle = 1'b0;
		drain_table();
		in_valid <= 1'b0;

		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (ENTRIES + 8) @(posedge clk);

		$display("%0d results checked: ok %0d, table full %0d, absent %0d, saturated %0d",
			results_checked, status_tally[STAT_OK], status_tally[STAT_FULL],
			status_tally[STAT_ABSENT], status_tally[STAT_SAT]);
		$display("occupancy peaked at %0d of %0d slots, count peaked at %0d",
			peak_fill, ENTRIES, peak_count);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
